// ----- hdl/mkv_pkg.sv -----
`timescale 1ns / 1ps

package mkv_pkg;

    // Fixed geometry of the key table and the alphabet.
    localparam int MAX_KEYS      = 4;
    localparam int MAX_KEY_LEN   = 16;
    localparam int ALPHABET_SIZE = 26;

    // Character constants.
    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;

    // Input command codes.
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_PROCESS = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_ACTIVE_KEYS  = 3'd0;
    localparam logic [2:0] REG_KEY_LENGTH_0 = 3'd1;
    localparam logic [2:0] REG_KEY_LENGTH_1 = 3'd2;
    localparam logic [2:0] REG_KEY_LENGTH_2 = 3'd3;
    localparam logic [2:0] REG_KEY_LENGTH_3 = 3'd4;
    localparam logic [2:0] REG_DECRYPT_MODE = 3'd5;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] key_select;
        logic [3:0] key_position;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       was_letter;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_PROCESS = 2'd1,
        OP_RESTART = 2'd2
    } op_kind_t;

    // Classified operation passed from the front end to the back end.
    typedef struct packed {
        op_kind_t   kind;
        logic [1:0] key_select;
        logic [3:0] key_position;
        logic [4:0] shift;
        logic       letter;
        logic       upper;
        logic [4:0] letter_idx;
        logic [7:0] data_byte;
    } op_t;

    // Decoded configuration seen by the back end.
    typedef struct packed {
        logic [MAX_KEYS-1:0]      key_en;
        logic [MAX_KEYS-1:0][3:0] key_last;
        logic                     decrypt;
    } cfg_t;

    function automatic logic [4:0] char_to_shift(input logic [7:0] ch);
        logic [7:0] up_off;
        logic [7:0] lo_off;
        up_off = 8'(ch - CHAR_UPPER_A);
        lo_off = 8'(ch - CHAR_LOWER_A);
        if (ch >= CHAR_0 && ch <= CHAR_9)
        begin
            return 5'(ch - CHAR_0);
        end
        if (ch >= CHAR_UPPER_A && up_off < 8'(ALPHABET_SIZE))
        begin
            return 5'(up_off);
        end
        if (ch >= CHAR_LOWER_A && lo_off < 8'(ALPHABET_SIZE))
        begin
            return 5'(lo_off);
        end
        return 5'd0;
    endfunction

    // Both operands are below the alphabet size.
    function automatic logic [4:0] add_mod(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = 6'(a) + 6'(b);
        if (s >= 6'(ALPHABET_SIZE))
        begin
            s = 6'(s - 6'(ALPHABET_SIZE));
        end
        return 5'(s);
    endfunction

    function automatic logic [4:0] sub_mod(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = 6'(6'(a) + 6'(ALPHABET_SIZE) - 6'(b));
        if (s >= 6'(ALPHABET_SIZE))
        begin
            s = 6'(s - 6'(ALPHABET_SIZE));
        end
        return 5'(s);
    endfunction

endpackage

// ----- hdl/multi_key_vigenere_cipher_core.sv -----
`timescale 1ns / 1ps

// Cascaded Vigenere cipher core. Items go in through a queue-style port (push/full) and
// results come out through another (pop/empty). A load command stores the shift of one
// key character, a restart command clears every key position, and a process command
// turns one text byte into exactly one result; loads, restarts and the unused command
// code produce no result. The block takes one item per clock cycle while the result side
// keeps up. A front end classifies each item in the cycle it is accepted and writes it
// into a two-entry operation queue; the back end executes one operation per cycle unless
// stalled, reading the shift at every active key position from per-key tables and
// advancing the key position registers in that same cycle, which is what sets the
// one-item-per-cycle rate. An item and its result pass through the registered operation
// and result queues before the result shows on the result ports; the two-entry result
// queue keeps the back end running while the consumer takes one result per cycle. When
// the result side stalls, text bytes back up into the operation queue and full rises
// once it holds two. The key table comes out of reset undefined; every key character
// that a process command will read must be loaded first. Configuration writes are always
// taken (cfg_ready is held high) and must only be made while the block is idle; writes
// to indexes beyond the decrypt mode register are ignored.

module multi_key_vigenere_cipher_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  mkv_pkg::in_item_t  item,
    input  logic               pop,
    output logic               empty,
    output mkv_pkg::out_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [4:0]         cfg_data
);

    localparam int OP_W  = $bits(mkv_pkg::op_t);
    localparam int RES_W = $bits(mkv_pkg::out_item_t);

    logic [2:0]                        active_keys_reg;
    logic [mkv_pkg::MAX_KEYS-1:0][4:0] key_length_reg;
    logic                              decrypt_mode_reg;

    mkv_pkg::cfg_t      cfg;
    mkv_pkg::op_t       fe_op;
    mkv_pkg::op_t       be_op;
    mkv_pkg::out_item_t be_res;
    logic [OP_W-1:0]    be_op_bits;
    logic [RES_W-1:0]   res_bits;
    logic [2:0]         eff_keys;
    logic               op_full, op_empty, op_push, op_pop;
    logic               res_full, res_push;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_keys_reg  <= 3'd1;
            key_length_reg   <= {mkv_pkg::MAX_KEYS{5'd1}};
            decrypt_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mkv_pkg::REG_ACTIVE_KEYS:  active_keys_reg   <= cfg_data[2:0];
                mkv_pkg::REG_KEY_LENGTH_0: key_length_reg[0] <= cfg_data;
                mkv_pkg::REG_KEY_LENGTH_1: key_length_reg[1] <= cfg_data;
                mkv_pkg::REG_KEY_LENGTH_2: key_length_reg[2] <= cfg_data;
                mkv_pkg::REG_KEY_LENGTH_3: key_length_reg[3] <= cfg_data;
                mkv_pkg::REG_DECRYPT_MODE: decrypt_mode_reg  <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    // Out-of-range settings are clamped: a count or length of zero acts as one, and
    // values above the table size act as the table size. Each length is kept as the
    // index of the key's last character, where its position wraps to zero.
    always_comb
    begin
        if (active_keys_reg == 3'd0)
        begin
            eff_keys = 3'd1;
        end
        else if (active_keys_reg > 3'(mkv_pkg::MAX_KEYS))
        begin
            eff_keys = 3'(mkv_pkg::MAX_KEYS);
        end
        else
        begin
            eff_keys = active_keys_reg;
        end

        for (int k = 0; k < mkv_pkg::MAX_KEYS; k++)
        begin
            cfg.key_en[k] = (3'(k) < eff_keys);
            if (key_length_reg[k] == 5'd0)
            begin
                cfg.key_last[k] = 4'd0;
            end
            else if (key_length_reg[k] > 5'(mkv_pkg::MAX_KEY_LEN))
            begin
                cfg.key_last[k] = 4'(mkv_pkg::MAX_KEY_LEN - 1);
            end
            else
            begin
                cfg.key_last[k] = 4'(key_length_reg[k] - 5'd1);
            end
        end
        cfg.decrypt = decrypt_mode_reg;
    end

    mkv_front u_front (
        .push    (push),
        .item    (item),
        .full    (full),
        .op_full (op_full),
        .op_push (op_push),
        .op      (fe_op)
    );

    mkv_fifo #(
        .WIDTH (OP_W),
        .DEPTH (2)
    ) u_op_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (op_push),
        .wr_data (fe_op),
        .full    (op_full),
        .rd_en   (op_pop),
        .rd_data (be_op_bits),
        .empty   (op_empty)
    );

    assign be_op = mkv_pkg::op_t'(be_op_bits);

    mkv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .op_valid (!op_empty),
        .op       (be_op),
        .op_pop   (op_pop),
        .res_full (res_full),
        .res_push (res_push),
        .res_data (be_res)
    );

    mkv_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (be_res),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_bits),
        .empty   (empty)
    );

    assign result = mkv_pkg::out_item_t'(res_bits);

endmodule

// ----- hdl/mkv_fifo.sv -----
`timescale 1ns / 1ps

module mkv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = CW'(count_reg + 1'b1);
            2'b01:   count_next = CW'(count_reg - 1'b1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/mkv_front.sv -----
`timescale 1ns / 1ps

module mkv_front (
    input  logic              push,
    input  mkv_pkg::in_item_t item,
    output logic              full,
    input  logic              op_full,
    output logic              op_push,
    output mkv_pkg::op_t      op
);

    logic [7:0] up_off;
    logic [7:0] lo_off;
    logic       is_upper;
    logic       is_lower;

    assign full = op_full;

    // The unused command code is dropped here and never reaches the back end.
    assign op_push = push && !op_full && (item.command != mkv_pkg::CMD_UNUSED);

    always_comb
    begin
        up_off   = 8'(item.data_byte - mkv_pkg::CHAR_UPPER_A);
        lo_off   = 8'(item.data_byte - mkv_pkg::CHAR_LOWER_A);
        is_upper = (item.data_byte >= mkv_pkg::CHAR_UPPER_A)
                   && (up_off < 8'(mkv_pkg::ALPHABET_SIZE));
        is_lower = (item.data_byte >= mkv_pkg::CHAR_LOWER_A)
                   && (lo_off < 8'(mkv_pkg::ALPHABET_SIZE));

        case (item.command)
            mkv_pkg::CMD_LOAD:    op.kind = mkv_pkg::OP_LOAD;
            mkv_pkg::CMD_RESTART: op.kind = mkv_pkg::OP_RESTART;
            default:              op.kind = mkv_pkg::OP_PROCESS;
        endcase
        op.key_select   = item.key_select;
        op.key_position = item.key_position;
        op.shift        = mkv_pkg::char_to_shift(item.data_byte);
        op.letter       = is_upper || is_lower;
        op.upper        = is_upper;
        op.letter_idx   = is_upper ? 5'(up_off) : 5'(lo_off);
        op.data_byte    = item.data_byte;
    end

endmodule

// ----- hdl/mkv_back.sv -----
`timescale 1ns / 1ps

module mkv_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mkv_pkg::cfg_t      cfg,
    input  logic               op_valid,
    input  mkv_pkg::op_t       op,
    output logic               op_pop,
    input  logic               res_full,
    output logic               res_push,
    output mkv_pkg::out_item_t res_data
);

    logic [4:0] cur_shift [mkv_pkg::MAX_KEYS];

    logic [mkv_pkg::MAX_KEYS-1:0][3:0] cursor_reg, cursor_next;

    logic       exec;
    logic       advance;
    logic [4:0] sum;
    logic [4:0] new_idx;
    logic [7:0] base;

    // Only text bytes need room in the result queue.
    assign exec     = op_valid && ((op.kind != mkv_pkg::OP_PROCESS) || !res_full);
    assign op_pop   = exec;
    assign res_push = exec && (op.kind == mkv_pkg::OP_PROCESS);
    assign advance  = exec && (op.kind == mkv_pkg::OP_PROCESS) && op.letter;

    // Each key has its own small shift table, so every active key is read in the same cycle.
    for (genvar g = 0; g < mkv_pkg::MAX_KEYS; g++)
    begin : g_key_table
        logic [4:0] shift_mem [mkv_pkg::MAX_KEY_LEN];

        always_ff @(posedge clk)
        begin
            if (exec && (op.kind == mkv_pkg::OP_LOAD) && (op.key_select == 2'(g)))
            begin
                shift_mem[op.key_position] <= op.shift;
            end
        end

        assign cur_shift[g] = shift_mem[cursor_reg[g]];
    end

    always_comb
    begin
        sum = 5'd0;
        for (int k = 0; k < mkv_pkg::MAX_KEYS; k++)
        begin
            if (cfg.key_en[k])
            begin
                sum = mkv_pkg::add_mod(sum, cur_shift[k]);
            end
        end
        new_idx = cfg.decrypt ? mkv_pkg::sub_mod(op.letter_idx, sum)
                              : mkv_pkg::add_mod(op.letter_idx, sum);
        base    = op.upper ? mkv_pkg::CHAR_UPPER_A : mkv_pkg::CHAR_LOWER_A;

        res_data.was_letter = op.letter;
        res_data.out_byte   = op.letter ? 8'(base + 8'(new_idx)) : op.data_byte;
    end

    always_comb
    begin
        cursor_next = cursor_reg;
        if (exec && (op.kind == mkv_pkg::OP_RESTART))
        begin
            cursor_next = '0;
        end
        else if (advance)
        begin
            for (int k = 0; k < mkv_pkg::MAX_KEYS; k++)
            begin
                if (cfg.key_en[k])
                begin
                    cursor_next[k] = (cursor_reg[k] >= cfg.key_last[k]) ? 4'd0
                                     : 4'(cursor_reg[k] + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
        end
    end

    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result written into a full result queue");

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (op.kind == mkv_pkg::OP_RESTART)) |=> (cursor_reg == '0))
        else $error("key positions not cleared by restart");

    a_non_letter_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (op.kind == mkv_pkg::OP_PROCESS) && !op.letter) |=> $stable(cursor_reg))
        else $error("key positions moved on a non-letter");

    a_inactive_key_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg.key_en[mkv_pkg::MAX_KEYS-1]) |=>
            $stable(cursor_reg[mkv_pkg::MAX_KEYS-1]))
        else $error("inactive key position advanced");

endmodule
